// ----- rtl/core/histogram_equalizer_top_defines.svh -----
// Assertion macros shared by the histogram equalizer RTL.
`ifndef HISTOGRAM_EQUALIZER_TOP_DEFINES_SVH
`define HISTOGRAM_EQUALIZER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every clock edge outside reset.
`define HE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("histeq assertion failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define HE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("histeq assertion failed");
`else
`define HE_ASSERT_IMP(lbl, ante, cons)
`define HE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/histeq_pkg.sv -----
// Types, constants and helpers of the histogram equalizer.
`default_nettype none
package histeq_pkg;

    localparam int LEVELS     = 256;
    localparam int COUNT_BITS = 24;
    localparam int GRAY_BITS  = 8;
    localparam int LVL_BITS   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int QUO_BITS   = 8;
    localparam int STEP_BITS  = 3;
    // 510 * cdf + total fits in COUNT_BITS + 9 bits
    localparam int NUM_BITS   = COUNT_BITS + 9;
    localparam int MAP_SCALE  = 510;

    typedef logic [LVL_BITS-1:0]   t_lvl;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [NUM_BITS-1:0]   t_num;
    typedef logic [GRAY_BITS-1:0]  t_gray;

    localparam t_count COUNT_MAX = '1;

    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT_WR,
        ST_BLD_RD,
        ST_BLD_ACC,
        ST_BLD_DIV,
        ST_MAP_LD
    } t_state;

    // Gray value to bin index, clamping values beyond the last bin
    function automatic t_lvl bin_of(input t_gray gray);
        if (int'(gray) >= LEVELS) begin
            return t_lvl'(LEVELS - 1);
        end else begin
            return t_lvl'(gray);
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/histeq_in_if.sv -----
// Input pixel request channel of the histogram equalizer.
`default_nettype none
interface histeq_in_if import histeq_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  cmd;
    t_gray gray;
    logic  last;

    modport source (output valid, output cmd, output gray, output last, input ready);
    modport sink   (input valid, input cmd, input gray, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/histeq_out_if.sv -----
// Result request channel of the histogram equalizer.
`default_nettype none
interface histeq_out_if import histeq_pkg::*; ();
    logic  valid;
    logic  ready;
    t_gray equalized;
    logic  empty_image;

    modport source (output valid, output equalized, output empty_image, input ready);
    modport sink   (input valid, input equalized, input empty_image, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/histogram_equalizer_top.sv -----
// Top level of the two-pass grayscale histogram equalizer.
//
// Count requests (cmd 0) add the pixel to a LEVELS-bin histogram held in a
// synchronous RAM; each is a RAM read, then an increment and write
// back, and no result is returned. A count request marked last with a
// nonzero pixel total then builds the level map: for each bin the RAM is
// read, the running cdf is scaled by 510 and offset by the total, and an
// 8-step restoring divider by 2*total produces the entry; no further
// request is taken until the whole map is built. Map requests (cmd 1)
// read the map RAM, then load the output register, waiting while a
// previous result is still held by the output side. A map request marked
// last clears the histogram at once through per-bin valid bits; there is
// no clearing pass.
// Mapping before a finished count pass returns 0 with empty_image set.
`default_nettype none
`include "histogram_equalizer_top_defines.svh"
module histogram_equalizer_top import histeq_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    histeq_in_if.sink   i_in,
    histeq_out_if.source o_out
);

    // Storage
    t_count bin_mem [LEVELS];
    t_gray  map_mem [LEVELS];
    logic [LEVELS-1:0] r_bin_vld;

    t_state r_state, n_state;
    t_count r_total;
    logic   r_map_ready;
    logic   r_inc;
    logic   r_last;
    logic   r_hit;
    t_lvl   r_addr;
    t_lvl   r_lvl;
    t_count r_cdf;
    t_num   r_rem;
    logic [QUO_BITS-1:0]  r_quo;
    logic [STEP_BITS-1:0] r_step;
    t_count r_bin_rd;
    logic   r_rd_vld;
    t_gray  r_map_rd;
    logic   r_out_valid;
    t_gray  r_out_eq;
    logic   r_out_empty;

    logic   s_in_rdy;
    logic   s_accept;
    logic   s_out_free;
    logic   s_out_load;
    logic   s_bin_rd_en;
    t_lvl   s_in_bin;
    t_lvl   s_bin_addr;
    t_count s_bin_val;
    t_count n_cdf;
    t_num   s_div_sub;
    logic   s_div_ge;
    logic [QUO_BITS-1:0] n_quo;
    logic   s_lvl_end;

    assign s_in_bin   = bin_of(i_in.gray);
    assign s_accept   = i_in.valid && s_in_rdy;
    assign s_out_free = !r_out_valid || o_out.ready;
    assign s_lvl_end  = (r_lvl == t_lvl'(LEVELS - 1));
    assign s_bin_val  = r_rd_vld ? r_bin_rd : '0;
    assign n_cdf      = r_cdf + s_bin_val;
    assign s_div_sub  = t_num'({r_total, 1'b0}) << r_step;
    assign s_div_ge   = (r_rem >= s_div_sub);
    assign n_quo      = {r_quo[QUO_BITS-2:0], s_div_ge};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = (i_in.cmd == CMD_MAP) ? ST_MAP_LD : ST_CNT_WR;
                end
            end
            ST_CNT_WR: begin
                n_state = (r_last && (r_total != '0)) ? ST_BLD_RD : ST_IDLE;
            end
            ST_BLD_RD:  n_state = ST_BLD_ACC;
            ST_BLD_ACC: n_state = ST_BLD_DIV;
            ST_BLD_DIV: begin
                if (r_step == '0) begin
                    n_state = s_lvl_end ? ST_IDLE : ST_BLD_RD;
                end
            end
            ST_MAP_LD: begin
                if (s_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_in_rdy    = 1'b0;
        s_out_load  = 1'b0;
        s_bin_rd_en = 1'b0;
        s_bin_addr  = s_in_bin;
        unique case (r_state)
            ST_IDLE: begin
                s_in_rdy    = 1'b1;
                s_bin_rd_en = s_accept && (i_in.cmd == CMD_COUNT);
            end
            ST_BLD_RD: begin
                s_bin_rd_en = 1'b1;
                s_bin_addr  = r_lvl;
            end
            ST_MAP_LD:  s_out_load = s_out_free;
            ST_CNT_WR, ST_BLD_ACC, ST_BLD_DIV: begin
                s_in_rdy = 1'b0;
            end
            default: s_in_rdy = 1'b0;
        endcase
    end

    // Histogram RAM: registered read, write back of the increment
    always_ff @(posedge i_clk) begin
        if (s_bin_rd_en) begin
            r_bin_rd <= bin_mem[s_bin_addr];
        end
        if ((r_state == ST_CNT_WR) && r_inc) begin
            bin_mem[r_addr] <= s_bin_val + t_count'(1);
        end
    end

    // Map RAM: written by the divider, read by map requests
    always_ff @(posedge i_clk) begin
        if (s_accept && (i_in.cmd == CMD_MAP)) begin
            r_map_rd <= map_mem[s_in_bin];
        end
        if ((r_state == ST_BLD_DIV) && (r_step == '0)) begin
            map_mem[r_lvl] <= n_quo;
        end
    end

    // Request capture and map build datapath
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_addr <= s_in_bin;
            r_last <= i_in.last;
        end
        if (s_bin_rd_en) begin
            r_rd_vld <= r_bin_vld[s_bin_addr];
        end
        if ((r_state == ST_CNT_WR) && (n_state == ST_BLD_RD)) begin
            r_lvl <= '0;
            r_cdf <= '0;
        end
        if (r_state == ST_BLD_ACC) begin
            r_cdf  <= n_cdf;
            r_rem  <= t_num'(n_cdf) * t_num'(MAP_SCALE) + t_num'(r_total);
            r_step <= STEP_BITS'(QUO_BITS - 1);
            r_quo  <= '0;
        end
        if (r_state == ST_BLD_DIV) begin
            if (s_div_ge) begin
                r_rem <= r_rem - s_div_sub;
            end
            r_quo  <= n_quo;
            r_step <= r_step - STEP_BITS'(1);
            if ((r_step == '0) && !s_lvl_end) begin
                r_lvl <= r_lvl + t_lvl'(1);
            end
        end
        if (s_out_load) begin
            r_out_eq    <= r_hit ? r_map_rd : '0;
            r_out_empty <= !r_hit;
        end
    end

    // Control state: state, totals, valid bits, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_total     <= '0;
            r_map_ready <= 1'b0;
            r_bin_vld   <= '0;
            r_inc       <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // count request: bump total unless saturated
            if (s_accept && (i_in.cmd == CMD_COUNT)) begin
                r_inc <= (r_total != COUNT_MAX);
                if (r_total != COUNT_MAX) begin
                    r_total <= r_total + t_count'(1);
                end
            end
            // map request: sample map status, clear store on last
            if (s_accept && (i_in.cmd == CMD_MAP)) begin
                r_hit <= r_map_ready;
                if (i_in.last) begin
                    r_total     <= '0;
                    r_map_ready <= 1'b0;
                    r_bin_vld   <= '0;
                end
            end
            if ((r_state == ST_CNT_WR) && r_inc) begin
                r_bin_vld[r_addr] <= 1'b1;
            end
            if ((r_state == ST_BLD_DIV) && (r_step == '0) && s_lvl_end) begin
                r_map_ready <= 1'b1;
            end
            // hold the result until taken
            if (s_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_in.ready        = s_in_rdy;
    assign o_out.valid       = r_out_valid;
    assign o_out.equalized   = r_out_eq;
    assign o_out.empty_image = r_out_empty;

    // Assertions
    `HE_ASSERT_NXT(a_map_to_load, s_accept && (i_in.cmd == CMD_MAP), r_state == ST_MAP_LD)
    `HE_ASSERT_IMP(a_empty_zero, o_out.valid && o_out.empty_image, o_out.equalized == '0)
    `HE_ASSERT_IMP(a_ready_total, r_map_ready, r_total != '0)
    `HE_ASSERT_NXT(a_build_done,
        (r_state == ST_BLD_DIV) && (r_step == '0) && s_lvl_end, r_map_ready)
    `HE_ASSERT_IMP(a_div_bound, r_state == ST_BLD_DIV,
        r_rem < (s_div_sub << 1))

endmodule
`default_nettype wire
